FILE: rtl/core/rctm_pkg.sv
// Shared types, constants and helper functions for the RC tank mixer.
`timescale 1ns / 1ps
`default_nettype none
package rctm_pkg;

  localparam int PULSE_BITS  = 12;
  localparam int LAST_W      = 12;
  localparam int VW          = PULSE_BITS + 6;
  localparam int PROD_W      = PULSE_BITS + 8;
  localparam int PART_W      = PULSE_BITS + 1;
  localparam int SUM_W       = PART_W + 2;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 3;

  localparam int CENTER          = 1500;
  localparam int SW_LOW_LIMIT    = 1450;
  localparam int SW_HIGH_LIMIT   = 1550;
  localparam int VALVE_DIV       = 200;
  localparam int THR_OFF_LIMIT   = -100;
  localparam int THR_REV_LIMIT   = -50;
  localparam int STEER_BAND      = 50;
  localparam int STEER_TURN      = 250;

  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_BITS  = 25;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_SHIFT) + VALVE_DIV - 1) / VALVE_DIV;

  localparam logic [CFG_INDEX_W-1:0] CFG_VALVE_DEADBAND  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VALVE_GAIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_MIN_DUTY   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_MAX_DUTY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_SLEW_STEP  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_MIN_DUTY  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_MAX_DUTY  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_SLEW_STEP = 3'd7;

  localparam logic [1:0] SW_LOW  = 2'd0;
  localparam logic [1:0] SW_MID  = 2'd1;
  localparam logic [1:0] SW_HIGH = 2'd2;

  localparam logic [2:0] BLINK_OFF    = 3'd0;
  localparam logic [2:0] BLINK_LEFT   = 3'd1;
  localparam logic [2:0] BLINK_RIGHT  = 3'd2;
  localparam logic [2:0] BLINK_HAZARD = 3'd3;
  localparam logic [2:0] BLINK_STROBE = 3'd4;

  typedef struct packed {
    logic [PULSE_BITS-1:0] valve_a_pulse;
    logic [PULSE_BITS-1:0] valve_b_pulse;
    logic [PULSE_BITS-1:0] throttle_pulse;
    logic [PULSE_BITS-1:0] steering_pulse;
    logic [PULSE_BITS-1:0] valve_c_pulse;
    logic [PULSE_BITS-1:0] light_switch_pulse;
    logic [PULSE_BITS-1:0] blink_switch_pulse;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  left_duty;
    logic        left_forward;
    logic        left_reverse;
    logic [9:0]  right_duty;
    logic        right_forward;
    logic        right_reverse;
    logic [11:0] pump_pulse;
    logic [2:0]  blink_mode;
    logic        blink_changed;
    logic        reverse_light;
    logic        aux_light;
  } out_item_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0] throttle_pulse;
    logic [PULSE_BITS-1:0] steering_pulse;
    logic [PULSE_BITS-1:0] light_switch_pulse;
    logic [PULSE_BITS-1:0] blink_switch_pulse;
  } ctl_item_t;

  typedef struct packed {
    logic [9:0] duty;
    logic       fwd;
    logic       rev;
  } drive_t;

  function automatic logic [1:0] switch_pos(logic [PULSE_BITS-1:0] p);
    logic [1:0] r;
    if (p < PULSE_BITS'(SW_LOW_LIMIT)) r = SW_LOW;
    else if (p > PULSE_BITS'(SW_HIGH_LIMIT)) r = SW_HIGH;
    else r = SW_MID;
    return r;
  endfunction

  function automatic logic signed [VW-1:0] drive_target(logic signed [VW-1:0] t,
                                                        logic [8:0] mn,
                                                        logic [9:0] mx);
    logic signed [VW-1:0] mn_s;
    logic signed [VW-1:0] mx_s;
    logic signed [VW-1:0] r;
    mn_s = $signed(VW'(mn));
    mx_s = $signed(VW'(mx));
    if (t > -mn_s && t < mn_s) r = VW'(CENTER);
    else if (t < -mx_s) r = VW'(CENTER) - mx_s;
    else if (t > mx_s) r = VW'(CENTER) + mx_s;
    else r = VW'(CENTER) + t;
    return r;
  endfunction

  function automatic logic [LAST_W-1:0] slew(logic signed [VW-1:0] t,
                                             logic [LAST_W-1:0] last,
                                             logic [8:0] step);
    logic signed [VW-1:0] last_s;
    logic signed [VW-1:0] step_s;
    logic signed [VW-1:0] lim;
    logic signed [VW-1:0] r;
    last_s = $signed(VW'(last));
    step_s = $signed(VW'(step));
    r = t;
    if (last != '0 && step != '0) begin
      if (t < VW'(CENTER)) begin
        lim = last_s - step_s;
        if (lim > VW'(SW_LOW_LIMIT)) lim = VW'(SW_LOW_LIMIT);
        if (t < lim) r = lim;
      end else begin
        lim = last_s + step_s;
        if (lim < VW'(SW_HIGH_LIMIT)) lim = VW'(SW_HIGH_LIMIT);
        if (t > lim) r = lim;
      end
    end
    return r[LAST_W-1:0];
  endfunction

  function automatic drive_t drive_out(logic [LAST_W-1:0] u, logic [8:0] mn);
    logic [LAST_W-1:0] lo;
    logic [LAST_W-1:0] hi;
    drive_t r;
    lo = LAST_W'(CENTER) - LAST_W'(mn);
    hi = LAST_W'(CENTER) + LAST_W'(mn);
    r = '0;
    if (u < lo) begin
      r.rev  = 1'b1;
      r.duty = 10'(LAST_W'(CENTER) - u);
    end else if (u > hi) begin
      r.fwd  = 1'b1;
      r.duty = 10'(u - LAST_W'(CENTER));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rc_tank_mixer_with_slew_limit.sv
// Top level of the RC tank mixer: valve pump mix, tank drive mix with slew, blinker and lights.
// Frames pass the s1 and s2 registers into the output register; one frame per cycle while the output is not stalled.
// Two valve stages (gain multiply, reciprocal divide) feed a final stage holding slew state.
// The whole pipeline advances together whenever the output register is empty or taken.
// Synchronous active-low reset clears valid bits, slew and blink state, and loads
// register defaults.
`timescale 1ns / 1ps
`default_nettype none
module rc_tank_mixer_with_slew_limit
  import rctm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [8:0] valve_deadband_r;
  logic [7:0] valve_gain_r;
  logic [9:0] pump_min_r;
  logic [9:0] pump_max_r;
  logic [8:0] pump_step_r;
  logic [8:0] drive_min_r;
  logic [9:0] drive_max_r;
  logic [8:0] drive_step_r;

  logic advance;
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  ctl_item_t s1_ctl_r;
  ctl_item_t s2_ctl_r;
  out_item_t out_r;
  out_item_t out_nxt;

  logic [PART_W-1:0] part_a;
  logic [PART_W-1:0] part_b;
  logic [PART_W-1:0] part_c;

  logic [LAST_W-1:0] left_last_r,  left_last_nxt;
  logic [LAST_W-1:0] right_last_r, right_last_nxt;
  logic [LAST_W-1:0] pump_last_r,  pump_last_nxt;
  logic [2:0]        blink_last_r, blink_nxt;

  logic [SUM_W-1:0]     valve_sum;
  logic [SUM_W:0]       pump_demand;
  logic signed [VW-1:0] pump_tgt;
  logic signed [VW-1:0] thr_s;
  logic signed [VW-1:0] str_s;
  logic [1:0]           light_pos;
  logic [1:0]           blink_pos;
  drive_t               left_drv;
  drive_t               right_drv;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valve_deadband_r <= 9'd80;
      valve_gain_r     <= 8'd60;
      pump_min_r       <= 10'd100;
      pump_max_r       <= 10'd260;
      pump_step_r      <= 9'd20;
      drive_min_r      <= 9'd50;
      drive_max_r      <= 10'd500;
      drive_step_r     <= 9'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VALVE_DEADBAND:  valve_deadband_r <= cfg_wdata[8:0];
        CFG_VALVE_GAIN:      valve_gain_r     <= cfg_wdata[7:0];
        CFG_PUMP_MIN_DUTY:   pump_min_r       <= cfg_wdata[9:0];
        CFG_PUMP_MAX_DUTY:   pump_max_r       <= cfg_wdata[9:0];
        CFG_PUMP_SLEW_STEP:  pump_step_r      <= cfg_wdata[8:0];
        CFG_DRIVE_MIN_DUTY:  drive_min_r      <= cfg_wdata[8:0];
        CFG_DRIVE_MAX_DUTY:  drive_max_r      <= cfg_wdata[9:0];
        CFG_DRIVE_SLEW_STEP: drive_step_r     <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipeline when the result register is empty or taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  rctm_valve u_valve_a (
    .clk(clk), .en(advance), .pulse(in_data.valve_a_pulse),
    .deadband(valve_deadband_r), .gain(valve_gain_r), .part(part_a)
  );
  rctm_valve u_valve_b (
    .clk(clk), .en(advance), .pulse(in_data.valve_b_pulse),
    .deadband(valve_deadband_r), .gain(valve_gain_r), .part(part_b)
  );
  rctm_valve u_valve_c (
    .clk(clk), .en(advance), .pulse(in_data.valve_c_pulse),
    .deadband(valve_deadband_r), .gain(valve_gain_r), .part(part_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl_r.throttle_pulse     <= in_data.throttle_pulse;
      s1_ctl_r.steering_pulse     <= in_data.steering_pulse;
      s1_ctl_r.light_switch_pulse <= in_data.light_switch_pulse;
      s1_ctl_r.blink_switch_pulse <= in_data.blink_switch_pulse;
      s2_ctl_r                    <= s1_ctl_r;
      out_r                       <= out_nxt;
    end
  end

  // pump
  assign valve_sum   = SUM_W'(part_a) + SUM_W'(part_b) + SUM_W'(part_c);
  assign pump_demand = (SUM_W+1)'(valve_sum) + (SUM_W+1)'(pump_min_r);

  always_comb begin
    if (valve_sum == '0) pump_tgt = VW'(CENTER);
    else if (pump_demand > (SUM_W+1)'(pump_max_r))
      pump_tgt = $signed(VW'(pump_max_r)) + VW'(CENTER);
    else pump_tgt = $signed(VW'(pump_demand)) + VW'(CENTER);
  end

  // drive mix
  assign thr_s = $signed(VW'(s2_ctl_r.throttle_pulse)) - VW'(CENTER);
  assign str_s = $signed(VW'(s2_ctl_r.steering_pulse)) - VW'(CENTER);

  assign left_last_nxt  = slew(drive_target(thr_s + str_s, drive_min_r, drive_max_r),
                               left_last_r, drive_step_r);
  assign right_last_nxt = slew(drive_target(thr_s - str_s, drive_min_r, drive_max_r),
                               right_last_r, drive_step_r);
  assign pump_last_nxt  = slew(pump_tgt, pump_last_r, pump_step_r);

  assign left_drv  = drive_out(left_last_nxt, drive_min_r);
  assign right_drv = drive_out(right_last_nxt, drive_min_r);

  // blinker
  assign light_pos = switch_pos(s2_ctl_r.light_switch_pulse);
  assign blink_pos = switch_pos(s2_ctl_r.blink_switch_pulse);

  always_comb begin
    blink_nxt = blink_last_r;
    case (blink_pos)
      SW_MID:  blink_nxt = BLINK_HAZARD;
      SW_HIGH: blink_nxt = BLINK_STROBE;
      default: begin
        if (thr_s < VW'(THR_OFF_LIMIT) ||
            (str_s > -VW'(STEER_BAND) && str_s < VW'(STEER_BAND))) begin
          blink_nxt = BLINK_OFF;
        end else if (thr_s > VW'(THR_REV_LIMIT)) begin
          if (str_s < -VW'(STEER_TURN)) blink_nxt = BLINK_LEFT;
          else if (str_s > VW'(STEER_TURN)) blink_nxt = BLINK_RIGHT;
        end
      end
    endcase
  end

  always_comb begin
    out_nxt.left_duty     = left_drv.duty;
    out_nxt.left_forward  = left_drv.fwd;
    out_nxt.left_reverse  = left_drv.rev;
    out_nxt.right_duty    = right_drv.duty;
    out_nxt.right_forward = right_drv.fwd;
    out_nxt.right_reverse = right_drv.rev;
    out_nxt.pump_pulse    = pump_last_nxt;
    out_nxt.blink_mode    = blink_nxt;
    out_nxt.blink_changed = (blink_nxt != blink_last_r);
    out_nxt.reverse_light = (thr_s < VW'(THR_REV_LIMIT));
    out_nxt.aux_light     = (light_pos != SW_LOW);
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_last_r  <= '0;
      right_last_r <= '0;
      pump_last_r  <= '0;
      blink_last_r <= BLINK_OFF;
    end else if (advance && s2_valid_r) begin
      left_last_r  <= left_last_nxt;
      right_last_r <= right_last_nxt;
      pump_last_r  <= pump_last_nxt;
      blink_last_r <= blink_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/rctm_valve.sv
// Two-stage valve channel: fold, deadband, gain, then divide by the valve divisor.
`timescale 1ns / 1ps
`default_nettype none
module rctm_valve
  import rctm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [PULSE_BITS-1:0] pulse,
  input  wire logic [8:0]            deadband,
  input  wire logic [7:0]            gain,
  output logic      [PART_W-1:0]     part
);

  logic [PULSE_BITS-1:0]        off;
  logic [PULSE_BITS-1:0]        db;
  logic [PULSE_BITS-1:0]        excess;
  logic [PROD_W-1:0]            prod_nxt;
  logic [PROD_W-1:0]            prod_r;
  logic [PROD_W+RECIP_BITS-1:0] recip_prod;
  logic [PART_W-1:0]            part_nxt;
  logic [PART_W-1:0]            part_r;

  assign off = (pulse < PULSE_BITS'(CENTER)) ? PULSE_BITS'(CENTER) - pulse
                                             : pulse - PULSE_BITS'(CENTER);
  assign db       = PULSE_BITS'(deadband);
  assign excess   = (off < db) ? '0 : off - db;
  assign prod_nxt = PROD_W'(gain) * PROD_W'(excess);

  // divide by the constant through a rounded-up reciprocal, exact over this range
  assign recip_prod = (PROD_W+RECIP_BITS)'(prod_r) *
                      (PROD_W+RECIP_BITS)'(RECIP_BITS'(RECIP_M));
  assign part_nxt   = recip_prod[RECIP_SHIFT +: PART_W];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      part_r <= part_nxt;
    end
  end

  assign part = part_r;

endmodule
`default_nettype wire

FILE: sim/rctm_frame_checker.sv
// Frame checker for the RC tank mixer: predicts drive, pump, blinker and light outputs.
`timescale 1ns / 1ps
module rctm_frame_checker
  import rctm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     frames_in_flight,
  output int                     frames_seen
);

  localparam int MID_US = 1500;

  int r_valve_db, r_valve_gain, r_pump_min, r_pump_max;
  int r_pump_step, r_drv_min, r_drv_max, r_drv_step;

  int lt_prev, rt_prev, pump_prev;
  logic [2:0] blink_prev;

  out_item_t mixed_frames[$];
  out_item_t want;
  int errors = 0;
  int checked = 0;

  function automatic int fold_valve(int p);
    int off;
    off = (p < MID_US) ? MID_US - p : p - MID_US;
    if (off < r_valve_db) return 0;
    return (r_valve_gain * (off - r_valve_db)) / 200;
  endfunction

  function automatic logic [1:0] sw_level(int p);
    if (p < 1450) return SW_LOW;
    if (p > 1550) return SW_HIGH;
    return SW_MID;
  endfunction

  function automatic int pump_goal(int sum);
    int t;
    if (sum == 0) return MID_US;
    t = sum + r_pump_min;
    if (t > r_pump_max) return MID_US + r_pump_max;
    return MID_US + t;
  endfunction

  function automatic int drive_goal(int t);
    if (t > -r_drv_min && t < r_drv_min) return MID_US;
    if (t < -r_drv_max) return MID_US - r_drv_max;
    if (t > r_drv_max) return MID_US + r_drv_max;
    return MID_US + t;
  endfunction

  function automatic int ramp_limit(int t, int prev, int step);
    int lim;
    if (prev == 0 || step == 0) return t & 'hFFF;
    if (t < MID_US) begin
      lim = prev - step;
      if (lim > 1450) lim = 1450;
      if (t < lim) t = lim;
    end else begin
      lim = prev + step;
      if (lim < 1550) lim = 1550;
      if (t > lim) t = lim;
    end
    return t & 'hFFF;
  endfunction

  function automatic drive_t bridge(int u);
    drive_t d;
    d = '0;
    if (u < MID_US - r_drv_min) begin
      d.rev  = 1'b1;
      d.duty = 10'(MID_US - u);
    end else if (u > MID_US + r_drv_min) begin
      d.fwd  = 1'b1;
      d.duty = 10'(u - MID_US);
    end
    return d;
  endfunction

  function automatic out_item_t mix_frame(in_item_t f);
    int va, vb, vc, thr, str;
    logic [1:0] bsw;
    logic [2:0] b;
    drive_t ld, rd;
    out_item_t r;
    va  = fold_valve(int'(f.valve_a_pulse));
    vb  = fold_valve(int'(f.valve_b_pulse));
    vc  = fold_valve(int'(f.valve_c_pulse));
    thr = int'(f.throttle_pulse) - MID_US;
    str = int'(f.steering_pulse) - MID_US;
    bsw = sw_level(int'(f.blink_switch_pulse));
    lt_prev   = ramp_limit(drive_goal(thr + str), lt_prev, r_drv_step);
    rt_prev   = ramp_limit(drive_goal(thr - str), rt_prev, r_drv_step);
    pump_prev = ramp_limit(pump_goal(va + vb + vc), pump_prev, r_pump_step);
    ld = bridge(lt_prev);
    rd = bridge(rt_prev);
    b = blink_prev;
    if (bsw != SW_LOW) begin
      b = (bsw == SW_MID) ? BLINK_HAZARD : BLINK_STROBE;
    end else if (thr < -100 || (str > -50 && str < 50)) begin
      b = BLINK_OFF;
    end else if (thr > -50) begin
      if (str < -250) b = BLINK_LEFT;
      else if (str > 250) b = BLINK_RIGHT;
    end
    r.left_duty     = ld.duty;
    r.left_forward  = ld.fwd;
    r.left_reverse  = ld.rev;
    r.right_duty    = rd.duty;
    r.right_forward = rd.fwd;
    r.right_reverse = rd.rev;
    r.pump_pulse    = 12'(pump_prev);
    r.blink_mode    = b;
    r.blink_changed = (b != blink_prev);
    r.reverse_light = (thr < -50);
    r.aux_light     = (sw_level(int'(f.light_switch_pulse)) != SW_LOW);
    blink_prev = b;
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch on frame %0d, %s: expected %0d, got %0d",
                 checked, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      r_valve_db  = 80;
      r_valve_gain = 60;
      r_pump_min  = 100;
      r_pump_max  = 260;
      r_pump_step = 20;
      r_drv_min   = 50;
      r_drv_max   = 500;
      r_drv_step  = 20;
      lt_prev     = 0;
      rt_prev     = 0;
      pump_prev   = 0;
      blink_prev  = BLINK_OFF;
      mixed_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VALVE_DEADBAND:  r_valve_db   = int'(cfg_wdata & 10'h1FF);
          CFG_VALVE_GAIN:      r_valve_gain = int'(cfg_wdata & 10'h0FF);
          CFG_PUMP_MIN_DUTY:   r_pump_min   = int'(cfg_wdata);
          CFG_PUMP_MAX_DUTY:   r_pump_max   = int'(cfg_wdata);
          CFG_PUMP_SLEW_STEP:  r_pump_step  = int'(cfg_wdata & 10'h1FF);
          CFG_DRIVE_MIN_DUTY:  r_drv_min    = int'(cfg_wdata & 10'h1FF);
          CFG_DRIVE_MAX_DUTY:  r_drv_max    = int'(cfg_wdata);
          CFG_DRIVE_SLEW_STEP: r_drv_step   = int'(cfg_wdata & 10'h1FF);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (mixed_frames.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Result %h arrived with nothing expected", out_data);
        end else begin
          want = mixed_frames.pop_front();
          check_field("left_duty", want.left_duty, out_data.left_duty);
          check_field("left_forward", want.left_forward, out_data.left_forward);
          check_field("left_reverse", want.left_reverse, out_data.left_reverse);
          check_field("right_duty", want.right_duty, out_data.right_duty);
          check_field("right_forward", want.right_forward, out_data.right_forward);
          check_field("right_reverse", want.right_reverse, out_data.right_reverse);
          check_field("pump_pulse", want.pump_pulse, out_data.pump_pulse);
          check_field("blink_mode", want.blink_mode, out_data.blink_mode);
          check_field("blink_changed", want.blink_changed, out_data.blink_changed);
          check_field("reverse_light", want.reverse_light, out_data.reverse_light);
          check_field("aux_light", want.aux_light, out_data.aux_light);
          checked++;
        end
      end
      if (in_valid && !in_stall) mixed_frames.push_back(mix_frame(in_data));
    end
    mismatches       <= errors;
    frames_in_flight <= mixed_frames.size();
    frames_seen      <= checked;
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the RC tank mixer: clock, reset, frame and register stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
  import rctm_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASES        = 6;
  localparam int FRAMES_PER_PH = 221;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches, frames_in_flight, frames_seen;
  int in_gap_pct = 0;
  int out_gap_pct = 0;
  int stall_left = 0;
  int quiet = 0;
  int last_thr = 1500;
  int last_str = 1500;
  int directed_cnt = 0;

  logic [CFG_DATA_W-1:0] settings [5][8] = '{
    '{10'd500, 10'd200, 10'd1000, 10'd1000, 10'd500, 10'd500, 10'd1000, 10'd500},
    '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd20, 10'd255, 10'd1000, 10'd0, 10'd1, 10'd511, 10'd100, 10'd1},
    '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd80, 10'd60, 10'd100, 10'd260, 10'd20, 10'd50, 10'd500, 10'd20}
  };

  always #4 clk = ~clk;

  rc_tank_mixer_with_slew_limit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  rctm_frame_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .frames_in_flight(frames_in_flight),
    .frames_seen(frames_seen)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t make_frame(int va, int vb, int thr, int str, int vc,
                                          int lsw, int bsw);
    in_item_t f;
    f.valve_a_pulse      = 12'(va);
    f.valve_b_pulse      = 12'(vb);
    f.throttle_pulse     = 12'(thr);
    f.steering_pulse     = 12'(str);
    f.valve_c_pulse      = 12'(vc);
    f.light_switch_pulse = 12'(lsw);
    f.blink_switch_pulse = 12'(bsw);
    return f;
  endfunction

  function automatic int rand_pulse();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1000, 2000);
      6, 7:             return $urandom_range(1400, 1600);
      8:                return $urandom_range(0, 4095);
      default: begin
        case ($urandom_range(0, 6))
          0: return 0;
          1: return 4095;
          2: return 1449;
          3: return 1450;
          4: return 1550;
          5: return 1551;
          default: return 1500;
        endcase
      end
    endcase
  endfunction

  function automatic int nudge(int prev);
    int v;
    v = prev + int'($urandom_range(0, 60)) - 30;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  task automatic send_frame(in_item_t f);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    int thr, str;
    thr = ($urandom_range(0, 1) == 0) ? nudge(last_thr) : rand_pulse();
    str = ($urandom_range(0, 1) == 0) ? nudge(last_str) : rand_pulse();
    last_thr = thr;
    last_str = str;
    send_frame(make_frame(rand_pulse(), rand_pulse(), thr, str, rand_pulse(),
                          rand_pulse(), rand_pulse()));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(int row);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_wdata <= settings[row][i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_item_t edge_frames[$];
    int ph_in, ph_out;
    bit calm;
    for (int i = 0; i < 8; i++) settings[3][i] = CFG_DATA_W'($urandom_range(0, 1023));
    edge_frames = '{
      make_frame(1500, 1500, 1500, 1500, 1500, 1500, 1500),
      make_frame(0, 0, 0, 0, 0, 0, 0),
      make_frame(4095, 4095, 4095, 4095, 4095, 4095, 4095),
      make_frame(1500, 1500, 2000, 1500, 1500, 1449, 1450),
      make_frame(1500, 1500, 1000, 1500, 1500, 1450, 1449),
      make_frame(1500, 1500, 1550, 1900, 1500, 1550, 1449),
      make_frame(1500, 1500, 1550, 1100, 1500, 1551, 1449),
      make_frame(1500, 1500, 1425, 1900, 1500, 1449, 1449),
      make_frame(1500, 1500, 1450, 1800, 1500, 1449, 1449),
      make_frame(1500, 1500, 1449, 1549, 1500, 1449, 1449),
      make_frame(1500, 1500, 1500, 1451, 1500, 1449, 1551),
      make_frame(1500, 1500, 1500, 1500, 1500, 1449, 1500),
      make_frame(1500, 1500, 1400, 1400, 1500, 1449, 1449),
      make_frame(1580, 1420, 1500, 1500, 1579, 1449, 1449),
      make_frame(1581, 1419, 1500, 1500, 2500, 1449, 1449),
      make_frame(4095, 0, 1500, 1500, 4095, 1449, 1449),
      make_frame(1500, 1500, 1549, 1500, 1500, 1449, 1449),
      make_frame(1500, 1500, 1550, 1500, 1500, 1449, 1449),
      make_frame(1500, 1500, 1451, 1500, 1500, 1449, 1449),
      make_frame(1500, 1500, 1450, 1500, 1500, 1449, 1449),
      make_frame(1500, 1500, 2500, 2500, 1500, 1449, 1449),
      make_frame(1500, 1500, 500, 2500, 1500, 1449, 1449)
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    out_gap_pct <= 20;
    foreach (edge_frames[i]) send_frame(edge_frames[i]);
    directed_cnt = edge_frames.size();
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        load_setting(ph - 1);
      end
      ph_in  = (ph == PHASES - 1) ? 0 : 5 * $urandom_range(0, 6);
      ph_out = (ph == PHASES - 1) ? 0 : 5 * $urandom_range(0, 6);
      calm = 1'b0;
      for (int n = 0; n < FRAMES_PER_PH; n++) begin
        if (n % 50 == 0) begin
          calm = ($urandom_range(0, 2) == 0);
          in_gap_pct  = calm ? 0 : ph_in;
          out_gap_pct <= calm ? 0 : ph_out;
        end
        send_random();
      end
    end
    drain();
    $display("Checked %0d frames: %0d edge frames, the rest random across %0d register sets",
             frames_seen, directed_cnt, PHASES);
    $display("Register sets include all-zero, range maxima, masked wide writes and min above max");
    if (mismatches == 0 && frames_in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
